@@ hdl/vpic_pkg.sv @@
package vpic_pkg;

    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [6:0] W_SVR0  = 7'd32;
    localparam logic [6:0] W_IVR   = 7'd64;
    localparam logic [6:0] W_FVR   = 7'd65;
    localparam logic [6:0] W_ISR   = 7'd66;
    localparam logic [6:0] W_IPR   = 7'd67;
    localparam logic [6:0] W_IMR   = 7'd68;
    localparam logic [6:0] W_CISR  = 7'd69;
    localparam logic [6:0] W_IECR  = 7'd72;
    localparam logic [6:0] W_IDCR  = 7'd73;
    localparam logic [6:0] W_ICCR  = 7'd74;
    localparam logic [6:0] W_ISCR  = 7'd75;
    localparam logic [6:0] W_EOICR = 7'd76;
    localparam logic [6:0] W_SPU   = 7'd77;
    localparam logic [6:0] W_DCR   = 7'd78;
    localparam logic [6:0] W_FFER  = 7'd80;
    localparam logic [6:0] W_FFDR  = 7'd81;
    localparam logic [6:0] W_FFSR  = 7'd82;

    localparam logic [6:0] MODE_KEEP = 7'h67;
    localparam int         MODE_EDGE_BIT = 5;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch input beat
        logic search;    // run candidate search / table read
        logic execute;   // apply operation
        logic finish;    // refresh flags, present result
    } t_cmd;

endpackage

@@ hdl/vectored_priority_interrupt_controller_core.sv @@
// Beats are taken only in idle; each runs search, execute and finish, and
// o_valid is registered from finish. busy covers search, execute and finish.
// The candidate search over all sources is one registered step per beat.
// Reset (i_rst_n low, synchronous) clears all tables, masks, stack and flags.
// Results appear for one cycle only; the receiver cannot stall.
module vectored_priority_interrupt_controller_core #(
    parameter int NUM_SOURCES = 32,
    parameter int STACK_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_source_index,
    input  logic        i_line_level,
    input  logic [6:0]  i_word_index,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic        o_irq_line,
    output logic        o_fiq_line
);
    import vpic_pkg::*;

    t_cmd cmd;

    // sequence each beat: capture, search, execute, finish
    vpic_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .o_busy(busy), .o_cmd(cmd)
    );

    // hold all controller state and the priority logic
    vpic_dp #(.NUM_SOURCES(NUM_SOURCES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_operation(i_operation), .i_source_index(i_source_index),
        .i_line_level(i_line_level), .i_word_index(i_word_index),
        .i_write_data(i_write_data), .o_valid(o_valid),
        .o_read_data(o_read_data), .o_irq_line(o_irq_line), .o_fiq_line(o_fiq_line)
    );

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##3 o_valid) else $error("result not delivered");

endmodule

@@ hdl/vpic_ctrl.sv @@
module vpic_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output vpic_pkg::t_cmd o_cmd
);
    import vpic_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_EXEC, S_FINISH} t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_SEARCH;
            S_SEARCH: n_state = S_EXEC;
            S_EXEC:   n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_cmd.capture   = (r_state == S_IDLE) && i_start;
    assign o_cmd.search    = (r_state == S_SEARCH);
    assign o_cmd.execute   = (r_state == S_EXEC);
    assign o_cmd.finish    = (r_state == S_FINISH);

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.search, o_cmd.execute, o_cmd.finish}))
        else $error("more than one command");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.search ##1 o_cmd.execute ##1 o_cmd.finish)
        else $error("command sequence broken");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy)
        else $error("busy after finish");

endmodule

@@ hdl/vpic_dp.sv @@
module vpic_dp #(
    parameter int NUM_SOURCES = 32,
    parameter int STACK_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vpic_pkg::t_cmd i_cmd,
    input  logic [1:0]     i_operation,
    input  logic [4:0]     i_source_index,
    input  logic           i_line_level,
    input  logic [6:0]     i_word_index,
    input  logic [31:0]    i_write_data,
    output logic           o_valid,
    output logic [31:0]    o_read_data,
    output logic           o_irq_line,
    output logic           o_fiq_line
);
    import vpic_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [31:0] SRC_MASK = (NUM_SOURCES >= 32) ? 32'hFFFF_FFFF :
                                       ((32'd1 << NUM_SOURCES) - 32'd1);

    logic [6:0]  r_mode [NUM_SOURCES];
    logic [31:0] r_vec  [NUM_SOURCES];
    logic [3:0]  r_stack [STACK_DEPTH];
    logic [31:0] r_en, r_lvl, r_edge, r_ff, r_spu, r_dcr;
    logic [4:0]  r_cur;
    logic [CW-1:0] r_cnt;
    logic        r_irq, r_fiq, r_valid;
    logic [1:0]  r_op;
    logic [4:0]  r_src;
    logic        r_lv;
    logic [6:0]  r_word;
    logic [31:0] r_wd, r_rd;
    logic [3:0]  r_best;
    logic [4:0]  r_bsrc;
    logic [3:0]  r_top;
    logic [31:0] r_tval;
    logic [6:0]  r_tmode;

    logic [31:0] edge_mask, pend, elig;
    logic [31:0] lvl_hit [8];
    logic [7:0]  lvl_any;
    logic [31:0] win;
    logic [3:0]  best;
    logic [4:0]  bsrc;
    logic [3:0]  top;

    // pick the highest priority level present, then the lowest source in it
    always_comb begin
        edge_mask = '0;
        for (int i = 0; i < NUM_SOURCES; i++) edge_mask[i] = r_mode[i][MODE_EDGE_BIT];
        pend = ((r_lvl & ~edge_mask) | (r_edge & edge_mask)) & SRC_MASK;
        elig = pend & r_en & ~r_ff;
        for (int l = 0; l < 8; l++) begin
            lvl_hit[l] = '0;
            for (int i = 1; i < NUM_SOURCES; i++)
                lvl_hit[l][i] = elig[i] && (r_mode[i][2:0] == 3'(l));
            lvl_any[l] = |lvl_hit[l];
        end
        best = '0;
        win = '0;
        for (int l = 0; l < 8; l++) begin
            if (lvl_any[l]) begin
                best = 4'(l + 1);
                win = lvl_hit[l];
            end
        end
        bsrc = '0;
        for (int i = NUM_SOURCES - 1; i >= 1; i--) begin
            if (win[i]) bsrc = 5'(i);
        end
        top = '0;
        if (r_cnt != '0) top = r_stack[SW'(r_cnt - CW'(1))];
    end

    logic [4:0] tidx;
    logic       tok;
    always_comb begin
        tidx = r_word[4:0];
        if (r_word == W_IVR) tidx = bsrc;
        else if (r_word == W_FVR) tidx = '0;
        tok = (32'(tidx) < NUM_SOURCES);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation; r_src <= i_source_index; r_lv <= i_line_level;
            r_word <= i_word_index; r_wd <= i_write_data;
        end
        if (i_cmd.search) begin
            r_best <= best; r_bsrc <= bsrc; r_top <= top;
            r_tval  <= tok ? r_vec[tidx[$clog2(NUM_SOURCES)-1:0]] : '0;
            r_tmode <= tok ? r_mode[tidx[$clog2(NUM_SOURCES)-1:0]] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_mode[i] <= '0; r_vec[i] <= '0;
            end
            r_en <= '0; r_lvl <= '0; r_edge <= '0; r_ff <= '0; r_spu <= '0;
            r_dcr <= '0; r_cur <= '0; r_cnt <= '0; r_irq <= 1'b0; r_fiq <= 1'b0;
            r_valid <= 1'b0; r_rd <= '0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.execute) begin
                case (r_op)
                    OP_LINE: begin
                        r_rd <= '0;
                        if (32'(r_src) < NUM_SOURCES) begin
                            if (r_lv) begin
                                r_lvl[r_src] <= 1'b1;
                                if (r_mode[r_src][MODE_EDGE_BIT] && !r_lvl[r_src])
                                    r_edge[r_src] <= 1'b1;
                            end else begin
                                r_lvl[r_src] <= 1'b0;
                            end
                        end
                    end
                    OP_READ: begin
                        if (r_word < W_IVR) begin
                            r_rd <= r_word[5] ? r_tval : {25'd0, r_tmode};
                        end else begin
                            case (r_word)
                                W_IVR: begin
                                    if (r_best <= r_top) begin
                                        r_cur <= '0;
                                        if (32'(r_cnt) < STACK_DEPTH) begin
                                            r_stack[SW'(r_cnt)] <= r_top;
                                            r_cnt <= r_cnt + CW'(1);
                                        end
                                        r_rd <= r_spu;
                                    end else begin
                                        r_cur <= r_bsrc;
                                        if (32'(r_cnt) < STACK_DEPTH) begin
                                            r_stack[SW'(r_cnt)] <= r_best;
                                            r_cnt <= r_cnt + CW'(1);
                                        end
                                        if (r_tmode[MODE_EDGE_BIT]) r_edge[r_bsrc] <= 1'b0;
                                        r_rd <= r_tval;
                                    end
                                end
                                W_FVR: begin
                                    if (r_tmode[MODE_EDGE_BIT]) r_edge[0] <= 1'b0;
                                    r_rd <= r_tval;
                                end
                                W_ISR:  r_rd <= {27'd0, r_cur};
                                W_IPR:  r_rd <= pend;
                                W_IMR:  r_rd <= r_en;
                                W_CISR: r_rd <= {30'd0, r_irq, r_fiq};
                                W_SPU:  r_rd <= r_spu;
                                W_DCR:  r_rd <= r_dcr;
                                W_FFSR: r_rd <= r_ff;
                                default: r_rd <= '0;
                            endcase
                        end
                    end
                    OP_WRITE: begin
                        r_rd <= '0;
                        if (r_word < W_SVR0) begin
                            if (32'(r_word) < NUM_SOURCES)
                                r_mode[r_word[$clog2(NUM_SOURCES)-1:0]] <= r_wd[6:0] & MODE_KEEP;
                        end else if (r_word < W_IVR) begin
                            if (32'(r_word[4:0]) < NUM_SOURCES)
                                r_vec[r_word[$clog2(NUM_SOURCES)-1:0]] <= r_wd;
                        end else begin
                            case (r_word)
                                W_IECR:  r_en <= (r_en | r_wd) & SRC_MASK;
                                W_IDCR:  r_en <= r_en & ~r_wd;
                                W_ICCR:  r_edge <= r_edge & ~r_wd;
                                W_ISCR:  r_edge <= (r_edge | r_wd) & SRC_MASK;
                                W_EOICR: if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
                                W_SPU:   r_spu <= r_wd;
                                W_DCR:   r_dcr <= r_wd;
                                W_FFER:  r_ff <= (r_ff | (r_wd & ~32'd1)) & SRC_MASK;
                                W_FFDR:  r_ff <= r_ff & ~r_wd;
                                default: ;
                            endcase
                        end
                    end
                    default: r_rd <= '0;
                endcase
            end
            // flags only change on steps that refresh; recomputing on every
            // step matches since the flags are a function of state otherwise
            // untouched by non-refreshing steps except IVR spurious/FVR
            if (i_cmd.finish && r_op != OP_RSVD &&
                !(r_op == OP_READ && (r_word != W_IVR || r_best <= r_top) &&
                  !(r_word == W_FVR && r_tmode[MODE_EDGE_BIT])) &&
                !(r_op == OP_WRITE && (r_word >= W_SVR0 && r_word < W_IVR)) &&
                !(r_op == OP_WRITE && (r_word == W_SPU || r_word == W_DCR))) begin
                r_irq <= best > top;
                r_fiq <= (pend & r_en & (r_ff | 32'd1)) != '0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_rd;
    assign o_irq_line  = r_irq;
    assign o_fiq_line  = r_fiq;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= STACK_DEPTH) else $error("stack count overflow");
    a_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_valid) else $error("no strobe after finish");
    a_ff0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ff[0]) else $error("source 0 fast-forced");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import vpic_pkg::*;

    localparam int NSRC      = 32;
    localparam int DEPTH     = 8;
    localparam int WDOG_MAX  = 2000;
    localparam int RAND_BEATS = 1100;

    localparam logic [6:0] W_VEC0  = 7'd32;
    localparam logic [1:0] OP_BAD  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = OP_LINE;
    logic [4:0]  i_source_index = '0;
    logic        i_line_level = 1'b0;
    logic [6:0]  i_word_index = '0;
    logic [31:0] i_write_data = '0;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_irq_line;
    logic        o_fiq_line;

    always #1 i_clk = ~i_clk;

    vectored_priority_interrupt_controller_core #(
        .NUM_SOURCES(NSRC),
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_source_index (i_source_index),
        .i_line_level   (i_line_level),
        .i_word_index   (i_word_index),
        .i_write_data   (i_write_data),
        .o_valid        (o_valid),
        .o_read_data    (o_read_data),
        .o_irq_line     (o_irq_line),
        .o_fiq_line     (o_fiq_line)
    );

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        fiq;
    } t_reply;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  src;
        logic        lvl;
        logic [6:0]  word;
        logic [31:0] data;
        logic        has_want;   // row carries a typed-in expected reply
        t_reply      want;
    } t_row;

    // shadow of the controller state
    logic [6:0]  pic_mode [NSRC];
    logic [31:0] pic_vec  [NSRC];
    logic [31:0] pic_enable, pic_lines, pic_edges, pic_fast, pic_spu, pic_dcr;
    logic [4:0]  pic_cur;
    logic [3:0]  pic_stack [DEPTH];
    int          pic_depth;
    logic        pic_irq, pic_fiq;

    t_reply reply_queue [$];
    int     mismatches = 0;
    int     beats_sent = 0;
    int     replies_seen = 0;
    int     wdog = 0;
    int     idle_pct = 0;
    int     pushes_full = 0;
    int     spurious_reads = 0;

    function automatic logic [31:0] edge_bits();
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < NSRC; i++) m[i] = pic_mode[i][MODE_EDGE_BIT];
        return m;
    endfunction

    function automatic logic [31:0] pending_bits();
        logic [31:0] e;
        e = edge_bits();
        return (pic_lines & ~e) | (pic_edges & e);
    endfunction

    // highest-priority eligible IRQ source; level code 0 means none
    function automatic logic [3:0] pick_source(output logic [4:0] who);
        logic [31:0] elig;
        logic [3:0]  best, code;
        elig = pending_bits() & pic_enable & ~pic_fast;
        best = '0;
        who = '0;
        for (int i = 1; i < NSRC; i++) begin
            code = {1'b0, pic_mode[i][2:0]} + 4'd1;
            if (elig[i] && code > best) begin
                best = code;
                who = 5'(i);
            end
        end
        return best;
    endfunction

    function automatic logic [3:0] stack_top();
        return (pic_depth > 0) ? pic_stack[pic_depth-1] : 4'd0;
    endfunction

    function automatic void stack_push(logic [3:0] code);
        if (pic_depth < DEPTH) begin
            pic_stack[pic_depth] = code;
            pic_depth++;
        end else begin
            pushes_full++;
        end
    endfunction

    function automatic void update_flags();
        logic [4:0] who;
        logic [3:0] best;
        best = pick_source(who);
        pic_irq = best > stack_top();
        pic_fiq = |(pending_bits() & pic_enable & (pic_fast | 32'h1));
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < NSRC; i++) begin
            pic_mode[i] = '0;
            pic_vec[i] = '0;
        end
        for (int i = 0; i < DEPTH; i++) pic_stack[i] = '0;
        pic_enable = '0; pic_lines = '0; pic_edges = '0; pic_fast = '0;
        pic_spu = '0; pic_dcr = '0; pic_cur = '0; pic_depth = 0;
        pic_irq = 1'b0; pic_fiq = 1'b0;
    endfunction

    function automatic logic [31:0] reg_read(logic [6:0] w);
        logic [4:0]  who;
        logic [3:0]  best, cur;
        if (w < W_VEC0) return {25'b0, pic_mode[w[4:0]]};
        if (w < W_IVR) return pic_vec[w[4:0]];
        case (w)
            W_IVR: begin
                best = pick_source(who);
                cur = stack_top();
                if (best <= cur) begin
                    pic_cur = '0;
                    stack_push(cur);
                    spurious_reads++;
                    return pic_spu;
                end
                pic_cur = who;
                stack_push(best);
                if (pic_mode[who][MODE_EDGE_BIT]) pic_edges[who] = 1'b0;
                update_flags();
                return pic_vec[who];
            end
            W_FVR: begin
                if (pic_mode[0][MODE_EDGE_BIT]) begin
                    pic_edges[0] = 1'b0;
                    update_flags();
                end
                return pic_vec[0];
            end
            W_ISR:  return {27'b0, pic_cur};
            W_IPR:  return pending_bits();
            W_IMR:  return pic_enable;
            W_CISR: return {30'b0, pic_irq, pic_fiq};
            W_SPU:  return pic_spu;
            W_DCR:  return pic_dcr;
            W_FFSR: return pic_fast;
            default: return '0;
        endcase
    endfunction

    function automatic void reg_write(logic [6:0] w, logic [31:0] v);
        if (w < W_VEC0) begin
            pic_mode[w[4:0]] = v[6:0] & MODE_KEEP;
            update_flags();
            return;
        end
        if (w < W_IVR) begin
            pic_vec[w[4:0]] = v;
            return;
        end
        case (w)
            W_IECR:  begin pic_enable |= v; update_flags(); end
            W_IDCR:  begin pic_enable &= ~v; update_flags(); end
            W_ICCR:  begin pic_edges &= ~v; update_flags(); end
            W_ISCR:  begin pic_edges |= v; update_flags(); end
            W_EOICR: begin
                if (pic_depth > 0) pic_depth--;
                update_flags();
            end
            W_SPU:   pic_spu = v;
            W_DCR:   pic_dcr = v;
            W_FFER:  begin pic_fast |= (v & ~32'h1); update_flags(); end
            W_FFDR:  begin pic_fast &= ~v; update_flags(); end
            default: ;
        endcase
    endfunction

    function automatic t_reply predict_reply(t_row r);
        t_reply o;
        o.rdata = '0;
        case (r.op)
            OP_LINE: begin
                if (r.lvl) begin
                    if (pic_mode[r.src][MODE_EDGE_BIT] && !pic_lines[r.src])
                        pic_edges[r.src] = 1'b1;
                    pic_lines[r.src] = 1'b1;
                end else begin
                    pic_lines[r.src] = 1'b0;
                end
                update_flags();
            end
            OP_READ:  o.rdata = reg_read(r.word);
            OP_WRITE: reg_write(r.word, r.data);
            default: ;
        endcase
        o.irq = pic_irq;
        o.fiq = pic_fiq;
        return o;
    endfunction

    // Drive one beat: hold start until the block takes it, then drop it
    // unless the next beat follows right away.
    task automatic send_beat(t_row r, logic back_to_back);
        t_reply p;
        i_operation    <= r.op;
        i_source_index <= r.src;
        i_line_level   <= r.lvl;
        i_word_index   <= r.word;
        i_write_data   <= r.data;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = predict_reply(r);
        if (r.has_want && r.want !== p) begin
            mismatches++;
            if (mismatches <= 10)
                $display("row predictor disagrees: op %0d word %0d typed %h got %h",
                         r.op, r.word, r.want, p);
        end
        reply_queue.push_back(r.has_want ? r.want : p);
        beats_sent++;
        if (!back_to_back) start <= 1'b0;
    endtask

    function automatic t_row mk(logic [1:0] op, logic [4:0] src, logic lvl,
                                logic [6:0] word, logic [31:0] data);
        t_row r;
        r.op = op; r.src = src; r.lvl = lvl; r.word = word; r.data = data;
        r.has_want = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row mkw(logic [1:0] op, logic [4:0] src, logic lvl,
                                 logic [6:0] word, logic [31:0] data,
                                 logic [31:0] rd, logic irq, logic fiq);
        t_row r;
        r = mk(op, src, lvl, word, data);
        r.has_want = 1'b1;
        r.want = '{rdata: rd, irq: irq, fiq: fiq};
        return r;
    endfunction

    // Random beat: mostly well-formed interrupt traffic, some noise.
    function automatic t_row rand_row();
        int k;
        logic [31:0] d;
        k = $urandom_range(0, 99);
        d = $urandom();
        if ($urandom_range(0, 3) == 0) d = 32'h1 << $urandom_range(0, 31);
        if (k < 28) return mk(OP_LINE, 5'($urandom()), 1'($urandom()), 7'($urandom()), d);
        if (k < 40) return mk(OP_READ, 5'($urandom()), 1'($urandom()), W_IVR, d);
        if (k < 50) return mk(OP_WRITE, 5'($urandom()), 1'($urandom()), W_EOICR, d);
        if (k < 58) return mk(OP_WRITE, 5'($urandom()), 1'($urandom()),
                              7'($urandom_range(0, 31)), d);
        if (k < 62) return mk(OP_WRITE, 5'($urandom()), 1'($urandom()),
                              7'($urandom_range(32, 63)), d);
        if (k < 70) return mk(OP_WRITE, 5'($urandom()), 1'($urandom()),
                              7'($urandom_range(W_IECR, W_FFDR)), d);
        if (k < 85) return mk(OP_READ, 5'($urandom()), 1'($urandom()),
                              7'($urandom_range(0, W_FFSR)), d);
        if (k < 88) return mk(OP_BAD, 5'($urandom()), 1'($urandom()), 7'($urandom()), d);
        return mk(2'($urandom_range(OP_READ, OP_WRITE)), 5'($urandom()),
                  1'($urandom()), 7'($urandom()), d);
    endfunction

    // Check each strobed reply against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid) begin
            replies_seen++;
            if (reply_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: rdata %h irq %b fiq %b",
                             o_read_data, o_irq_line, o_fiq_line);
            end else begin
                exp_r = reply_queue.pop_front();
                if (o_read_data !== exp_r.rdata || o_irq_line !== exp_r.irq
                    || o_fiq_line !== exp_r.fiq) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d: want rdata %h irq %b fiq %b, saw %h %b %b",
                                 replies_seen, exp_r.rdata, exp_r.irq, exp_r.fiq,
                                 o_read_data, o_irq_line, o_fiq_line);
                end
            end
        end
    end

    // Watchdog: count cycles with no beat taken and no reply.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog: stuck with %0d replies outstanding", reply_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Each cycle the sender could offer a beat it stays idle with idle_pct odds.
    task automatic idle_gap();
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (reply_queue.size() != 0) @(posedge i_clk);
    endtask

    t_row dir_rows [$];

    initial begin
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: reset values, extremes and each special case
        dir_rows = '{
            mkw(OP_READ,  0, 0, W_IVR,   32'h0,        32'h0, 0, 0),  // spurious push
            mkw(OP_READ,  0, 0, W_CISR,  32'h0,        32'h0, 0, 0),
            mkw(OP_WRITE, 0, 0, W_EOICR, 32'h0,        32'h0, 0, 0),
            mkw(OP_WRITE, 0, 0, W_EOICR, 32'h0,        32'h0, 0, 0),  // empty pop
            mkw(OP_WRITE, 0, 0, 7'd127,  32'hFFFFFFFF, 32'h0, 0, 0),  // unmapped
            mkw(OP_READ,  0, 0, 7'd127,  32'h0,        32'h0, 0, 0),
            mkw(OP_BAD,   31, 1, W_IECR, 32'hFFFFFFFF, 32'h0, 0, 0),  // bad op
            mkw(OP_WRITE, 0, 0, W_SPU,   32'hFFFFFFFF, 32'h0, 0, 0),
            mkw(OP_READ,  0, 0, W_SPU,   32'h0,        32'hFFFFFFFF, 0, 0),
            mkw(OP_WRITE, 0, 0, 7'd31,   32'hFFFFFFFF, 32'h0, 0, 0),
            mkw(OP_READ,  0, 0, 7'd31,   32'h0,        32'h67, 0, 0),
            mk(OP_WRITE,  0, 0, 7'd63,   32'hDEADBEEF),
            mk(OP_WRITE,  0, 0, W_DCR,   32'hA5A5A5A5),
            mk(OP_READ,   0, 0, W_DCR,   32'h0),
            mk(OP_WRITE,  0, 0, W_IECR,  32'hFFFFFFFF),
            mk(OP_LINE,   31, 1, 7'd0,   32'h0),      // edge source fires
            mk(OP_READ,   0, 0, W_IPR,   32'h0),
            mk(OP_READ,   0, 0, W_IVR,   32'h0),
            mk(OP_READ,   0, 0, W_ISR,   32'h0),
            mk(OP_LINE,   0, 1, 7'd0,    32'h0),      // FIQ source
            mk(OP_READ,   0, 0, W_FVR,   32'h0),
            mk(OP_WRITE,  0, 0, W_FFER,  32'hFFFFFFFF),
            mk(OP_READ,   0, 0, W_FFSR,  32'h0),
            mk(OP_WRITE,  0, 0, W_FFDR,  32'hFFFFFFFF),
            mk(OP_WRITE,  0, 0, W_ISCR,  32'hFFFFFFFF)
        };
        foreach (dir_rows[i]) send_beat(dir_rows[i], 1'b1);
        // fill the stack past its depth, then clear edges and the enable mask
        repeat (DEPTH + 2) send_beat(mk(OP_READ, 0, 0, W_IVR, 32'h0), 1'b1);
        send_beat(mk(OP_WRITE, 0, 0, W_ICCR, 32'hFFFFFFFF), 1'b1);
        send_beat(mk(OP_WRITE, 0, 0, W_IDCR, 32'hFFFFFFFF), 1'b0);

        // hold off until every outstanding reply has arrived
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 80;
                2: idle_pct = 11;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RAND_BEATS / 4; n++) begin
                idle_gap();
                send_beat(rand_row(), 1'b1);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d beats, %0d replies, %0d spurious vector reads, %0d dropped pushes",
                 beats_sent, replies_seen, spurious_reads, pushes_full);
        if (mismatches == 0 && reply_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
